### sv/twzs_pkg.sv
// ----------------------------------------------------------------------------
// twzs_pkg
// Shared constants, types and helpers for the triggered window zero
// suppression block.
// ----------------------------------------------------------------------------
package twzs_pkg;

  localparam int PRE_DEPTH = 8192;
  localparam int PTR_W     = $clog2(PRE_DEPTH);
  localparam int CNT_W     = PTR_W + 1;

  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 32;
  localparam int THR_W     = 16;
  localparam int PRE_W     = 14;
  localparam int POST_W    = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_LEN  = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd0;
  localparam logic [PRE_W-1:0]  PRE_LEN_RESET   = 14'd7407;
  localparam logic [POST_W-1:0] POST_LEN_RESET  = 20'd74074;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // request from the front part, registered in the cycle after the accepted sample
  typedef struct packed {
    logic                emit;
    logic                bypass;
    logic [SAMPLE_W-1:0] raw;
    logic [INDEX_W-1:0]  index;
    logic                first;
  } twzs_job_t;

  // delay memory access issued by the front part
  typedef struct packed {
    logic                we;
    logic [PTR_W-1:0]    waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic                re;
    logic [PTR_W-1:0]    raddr;
  } twzs_ram_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]  index;
    logic                first;
  } twzs_entry_t;

  // a - b as a signed 32-bit distance is negative
  function automatic logic is_before(input logic [INDEX_W-1:0] a,
                                     input logic [INDEX_W-1:0] b);
    logic [INDEX_W-1:0] diff;
    diff = a - b;
    return diff[INDEX_W-1];
  endfunction

endpackage

### sv/twzs_ram.sv
// ----------------------------------------------------------------------------
// twzs_ram
// Generic single write port, single read port RAM with registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module twzs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/twzs_front.sv
// ----------------------------------------------------------------------------
// twzs_front
// Front part: holds configuration, tracks the trigger windows, addresses
// the delay memory and classifies each accepted sample as kept or dropped.
// ----------------------------------------------------------------------------
module twzs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [twzs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [twzs_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              accept,
  input  logic [twzs_pkg::SAMPLE_W-1:0]     sample_in,
  output twzs_pkg::twzs_ram_req_t           ram_req,
  output twzs_pkg::twzs_job_t               job
);

  logic [twzs_pkg::THR_W-1:0]   threshold;
  logic [twzs_pkg::PRE_W-1:0]   pre_len;
  logic [twzs_pkg::POST_W-1:0]  post_len;
  logic [twzs_pkg::PTR_W-1:0]   wp;
  logic [twzs_pkg::CNT_W-1:0]   fill_count;
  logic [twzs_pkg::INDEX_W-1:0] input_count;
  logic [twzs_pkg::INDEX_W-1:0] current_end;
  logic                         window_seen;
  logic                         last_emitted;
  logic                         job_emit;
  twzs_pkg::twzs_job_t          job_data;

  logic [twzs_pkg::CNT_W-1:0]   p;
  logic [twzs_pkg::POST_W-1:0]  post_eff;
  logic                         fill_ok;
  logic [twzs_pkg::CNT_W:0]     rd_sum;
  logic [twzs_pkg::PTR_W-1:0]   wp_next;
  logic                         below;
  logic [twzs_pkg::INDEX_W-1:0] m;
  logic [twzs_pkg::INDEX_W-1:0] current_end_next;
  logic                         window_seen_next;
  logic                         covered;
  logic                         emit;

  always_comb begin
    if (32'(pre_len) > 32'(twzs_pkg::PRE_DEPTH)) begin
      p = twzs_pkg::CNT_W'(twzs_pkg::PRE_DEPTH);
    end else begin
      p = twzs_pkg::CNT_W'(pre_len);
    end
    post_eff = (post_len == '0) ? twzs_pkg::POST_W'(1) : post_len;
    fill_ok  = (p <= fill_count);

    // tap pre samples back, wrapping around the delay store
    if ({1'b0, wp} >= p) begin
      rd_sum = (twzs_pkg::CNT_W+1)'(wp) - (twzs_pkg::CNT_W+1)'(p);
    end else begin
      rd_sum = (twzs_pkg::CNT_W+1)'(wp) + (twzs_pkg::CNT_W+1)'(twzs_pkg::PRE_DEPTH)
             - (twzs_pkg::CNT_W+1)'(p);
    end

    if (32'(wp) == 32'(twzs_pkg::PRE_DEPTH - 1)) begin
      wp_next = '0;
    end else begin
      wp_next = wp + twzs_pkg::PTR_W'(1);
    end

    below = $signed(sample_in) < $signed(threshold);

    current_end_next = current_end;
    window_seen_next = window_seen;
    if (below) begin
      if (window_seen && input_count == current_end) begin
        current_end_next = input_count + twzs_pkg::INDEX_W'(1);
      end else if (!window_seen || !twzs_pkg::is_before(input_count, current_end)) begin
        current_end_next = input_count + twzs_pkg::INDEX_W'(post_eff);
        window_seen_next = 1'b1;
      end
    end

    m       = input_count - twzs_pkg::INDEX_W'(p);
    covered = twzs_pkg::is_before(m, current_end_next);
    emit    = fill_ok && window_seen_next && covered;
    if (window_seen_next && !covered) begin
      window_seen_next = 1'b0;
    end
  end

  always_comb begin
    ram_req.we    = accept;
    ram_req.waddr = wp;
    ram_req.wdata = sample_in;
    ram_req.re    = accept;
    ram_req.raddr = rd_sum[twzs_pkg::PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= twzs_pkg::THRESHOLD_RESET;
      pre_len   <= twzs_pkg::PRE_LEN_RESET;
      post_len  <= twzs_pkg::POST_LEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        twzs_pkg::CFG_THRESHOLD: threshold <= cfg_data[twzs_pkg::THR_W-1:0];
        twzs_pkg::CFG_PRE_LEN:   pre_len   <= cfg_data[twzs_pkg::PRE_W-1:0];
        twzs_pkg::CFG_POST_LEN:  post_len  <= cfg_data[twzs_pkg::POST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= '0;
      fill_count   <= '0;
      input_count  <= '0;
      current_end  <= '0;
      window_seen  <= 1'b0;
      last_emitted <= 1'b0;
      job_emit     <= 1'b0;
    end else begin
      job_emit <= accept && emit;
      if (accept) begin
        wp           <= wp_next;
        input_count  <= input_count + twzs_pkg::INDEX_W'(1);
        current_end  <= current_end_next;
        window_seen  <= window_seen_next;
        last_emitted <= emit;
        if (32'(fill_count) < 32'(twzs_pkg::PRE_DEPTH)) begin
          fill_count <= fill_count + twzs_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_data.emit   <= emit;
      job_data.bypass <= (p == '0);
      job_data.raw    <= sample_in;
      job_data.index  <= m;
      job_data.first  <= !last_emitted;
    end
  end

  // the reset-qualified flag stands in for the unreset copy
  always_comb begin
    job      = job_data;
    job.emit = job_emit;
  end

  // fill count saturates at the delay depth
  assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= 32'(twzs_pkg::PRE_DEPTH))
    else $error("fill count beyond delay depth");

  // a kept sample always follows an accepted one
  assert property (@(posedge clk) disable iff (rst)
    job_emit |-> $past(accept))
    else $error("kept sample without accepted input");

endmodule

### sv/twzs_queue.sv
// ----------------------------------------------------------------------------
// twzs_queue
// Back part: short result queue that takes kept samples from the front
// part and hands them out oldest first.
// ----------------------------------------------------------------------------
module twzs_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_en,
  input  twzs_pkg::twzs_entry_t       push_data,
  input  logic                        pop_en,
  output twzs_pkg::twzs_entry_t       head,
  output logic                        empty,
  output logic [twzs_pkg::QCNT_W-1:0] count
);

  twzs_pkg::twzs_entry_t        store [twzs_pkg::QDEPTH];
  logic [twzs_pkg::QPTR_W-1:0]  wr_ptr;
  logic [twzs_pkg::QPTR_W-1:0]  rd_ptr;
  logic                         do_pop;

  assign empty  = (count == '0);
  assign head   = store[rd_ptr];
  assign do_pop = pop_en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr <= wr_ptr + twzs_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + twzs_pkg::QPTR_W'(1);
      end
      if (push_en && !do_pop) begin
        count <= count + twzs_pkg::QCNT_W'(1);
      end else if (!push_en && do_pop) begin
        count <= count - twzs_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      store[wr_ptr] <= push_data;
    end
  end

  // the credit check upstream keeps the queue from overflowing
  assert property (@(posedge clk) disable iff (rst)
    !(push_en && 32'(count) == twzs_pkg::QDEPTH))
    else $error("result queue overflow");

endmodule

### sv/triggered_window_zero_suppression.sv
// ----------------------------------------------------------------------------
// triggered_window_zero_suppression
// Zero suppression of an ADC stream around triggered windows.
// ----------------------------------------------------------------------------
// Takes one signed sample per clock while full is low. A sample below
// threshold outside any window opens a window of pre_len samples before
// it and post_len from it onward; the window keeps growing while the
// sample at its end is still below threshold. Kept samples come out
// pre_len samples late, with their stream index, through a four-entry
// result queue; a sample passes the delay memory read, then the queue
// write, before it reaches the queue head. full rises only when the queue
// and the request in flight hold four results, so with pop held high the
// block takes a sample every clock. The delay memory needs no clearing pass:
// after reset no result appears until pre_len samples have been stored.
// ----------------------------------------------------------------------------
module triggered_window_zero_suppression (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [twzs_pkg::SAMPLE_W-1:0]   sample_in,
  output logic                            empty,
  input  logic                            pop,
  output logic [twzs_pkg::SAMPLE_W-1:0]   sample_out,
  output logic [twzs_pkg::INDEX_W-1:0]    sample_index,
  output logic                            window_first,
  input  logic                            cfg_wr_en,
  input  logic [twzs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twzs_pkg::CFG_W-1:0]      cfg_data
);

  logic                          accept;
  twzs_pkg::twzs_ram_req_t       ram_req;
  twzs_pkg::twzs_job_t           job;
  logic [twzs_pkg::SAMPLE_W-1:0] ram_rdata;
  twzs_pkg::twzs_entry_t         push_data;
  twzs_pkg::twzs_entry_t         head;
  logic [twzs_pkg::QCNT_W-1:0]   q_count;
  logic [twzs_pkg::QCNT_W-1:0]   occupancy;

  // results queued plus the one still in flight
  assign occupancy = q_count + twzs_pkg::QCNT_W'(job.emit);
  assign full      = (32'(occupancy) >= twzs_pkg::QDEPTH);
  assign accept    = push && !full;

  twzs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .sample_in (sample_in),
    .ram_req   (ram_req),
    .job       (job)
  );

  twzs_ram #(
    .WIDTH (twzs_pkg::SAMPLE_W),
    .DEPTH (twzs_pkg::PRE_DEPTH)
  ) u_delay (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    push_data.sample = job.bypass ? job.raw : ram_rdata;
    push_data.index  = job.index;
    push_data.first  = job.first;
  end

  twzs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (job.emit),
    .push_data (push_data),
    .pop_en    (pop),
    .head      (head),
    .empty     (empty),
    .count     (q_count)
  );

  assign sample_out   = head.sample;
  assign sample_index = head.index;
  assign window_first = head.first;

  // in-flight credit never goes past the queue depth
  assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) <= twzs_pkg::QDEPTH)
    else $error("result credit exceeded");

endmodule
